[design/m3i_pkg.sv]
// ----------------------------------------------------------------------------
// m3i_pkg: shared types and constants for the 3x3 matrix inverse
// Word formats, pipeline stage positions, request/response payloads and the
// cofactor operand selection table.
// ----------------------------------------------------------------------------
package m3i_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int N_ELEM    = 9;

   localparam int PROD_W = 2 * WORD_BITS;
   localparam int COF_W  = PROD_W + 1;
   localparam int HI_W   = COF_W - WORD_BITS;
   localparam int PART_W = WORD_BITS + HI_W;
   localparam int DET_W  = WORD_BITS + COF_W + 2;
   localparam int NUM_W  = COF_W + 2 * FRAC_BITS;
   localparam int QR_W   = WORD_BITS + 1;

   // Stage positions: determinant ready after ST_DET, division starts at
   // ST_D0, one quotient bit per stage, then the rounding/output stage.
   localparam int ST_DET = 5;
   localparam int ST_D0  = 6;
   localparam int N_ST   = ST_D0 + WORD_BITS + 2;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic signed [COF_W-1:0]     cof_type;
   typedef logic [COF_W-1:0]            cof_mag_type;
   typedef logic [DET_W-1:0]            mag_type;
   typedef logic [N_ST-1:0]             stage_en_type;
   typedef mag_type [WORD_BITS:0]       dpipe_type;

   localparam word_type WORD_MAX = word_type'({1'b0, {(WORD_BITS-1){1'b1}}});
   localparam word_type WORD_MIN = word_type'({1'b1, {(WORD_BITS-1){1'b0}}});
   localparam logic [QR_W-1:0] QR_POS_LIM = {2'b00, {(WORD_BITS-1){1'b1}}};
   localparam logic [QR_W-1:0] QR_NEG_LIM = {2'b01, {(WORD_BITS-1){1'b0}}};

   // Operands p, q, s, t of each adjugate entry p*q - s*t (row-major).
   localparam int COF_SEL [N_ELEM][4] = '{
      '{4, 8, 7, 5}, '{7, 2, 1, 8}, '{1, 5, 4, 2},
      '{6, 5, 3, 8}, '{0, 8, 6, 2}, '{3, 2, 0, 5},
      '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}
   };

   typedef struct packed {
      word_type a00; word_type a01; word_type a02;
      word_type a10; word_type a11; word_type a12;
      word_type a20; word_type a21; word_type a22;
   } req_type;

   typedef struct packed {
      word_type inv00; word_type inv01; word_type inv02;
      word_type inv10; word_type inv11; word_type inv12;
      word_type inv20; word_type inv21; word_type inv22;
      logic     singular;
   } rsp_type;

   typedef struct packed {
      logic    singular;
      logic    neg;
      mag_type mag;
   } det_type;

endpackage

[design/m3i_if.sv]
// ----------------------------------------------------------------------------
// m3i_if: valid/ready channels for the matrix inverse
// One interface for requests (a matrix) and one for responses (its inverse).
// ----------------------------------------------------------------------------
interface m3i_req_if;
   import m3i_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface m3i_rsp_if;
   import m3i_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[design/matrix3_inverse.sv]
// Path from an accepted request to its response: the product and determinant
// stages, the bit-per-stage quotient pipeline, then 1 output register.
// Throughput: one request per cycle unless every stage is full and the
// response is stalled; any empty stage absorbs a request while a finished
// response waits. Reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
// matrix3_inverse: 3x3 fixed-point matrix inverse via the adjugate
// Nine cofactor lanes, a determinant merge, and nine division lanes.
// ----------------------------------------------------------------------------
module matrix3_inverse (
   input  logic       clock,
   input  logic       reset,
   m3i_req_if.sink    req,
   m3i_rsp_if.source  rsp
);
   import m3i_pkg::*;

   logic [N_ST-1:0] v_ff;
   stage_en_type    en;
   word_type        a_w [N_ELEM];
   cof_type         cof [N_ELEM];
   word_type        inv [N_ELEM];
   det_type         det;
   dpipe_type       dpipe_ff;
   logic [WORD_BITS:0] sing_ff;
   logic            sing_out_ff;

   assign a_w[0] = req.data.a00;
   assign a_w[1] = req.data.a01;
   assign a_w[2] = req.data.a02;
   assign a_w[3] = req.data.a10;
   assign a_w[4] = req.data.a11;
   assign a_w[5] = req.data.a12;
   assign a_w[6] = req.data.a20;
   assign a_w[7] = req.data.a21;
   assign a_w[8] = req.data.a22;

   // A stage may load when some stage at or after it is empty, or the
   // response is being taken.
   for (genvar s = 0; s < N_ST; s++) begin : g_en
      assign en[s] = rsp.ready | ~(&v_ff[N_ST-1:s]);
   end

   assign req.ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int s = 0; s < N_ST; s++) begin
            if (en[s]) v_ff[s] <= (s == 0) ? req.valid : v_ff[(s == 0) ? 0 : s-1];
         end
      end
   end

   // Divisor and singular flag travel alongside the quotient stages.
   always_ff @(posedge clock) begin
      if (en[ST_D0]) begin
         dpipe_ff[0] <= det.mag;
         sing_ff[0]  <= det.singular;
      end
      for (int k = 1; k <= WORD_BITS; k++) begin
         if (en[ST_D0+k]) begin
            dpipe_ff[k] <= dpipe_ff[k-1];
            sing_ff[k]  <= sing_ff[k-1];
         end
      end
      if (en[N_ST-1]) sing_out_ff <= sing_ff[WORD_BITS];
   end

   for (genvar i = 0; i < N_ELEM; i++) begin : g_lane
      m3i_cof_lane u_cof (
         .clock (clock),
         .en    (en[1:0]),
         .p     (a_w[COF_SEL[i][0]]),
         .q     (a_w[COF_SEL[i][1]]),
         .s     (a_w[COF_SEL[i][2]]),
         .t     (a_w[COF_SEL[i][3]]),
         .cof   (cof[i])
      );
      m3i_div_lane u_div (
         .clock (clock),
         .en    (en),
         .cof   (cof[i]),
         .det   (det),
         .dpipe (dpipe_ff),
         .sing  (sing_ff[WORD_BITS]),
         .inv   (inv[i])
      );
   end

   m3i_det u_det (
      .clock (clock),
      .en    (en[ST_DET:0]),
      .a0    (a_w[0]),
      .a1    (a_w[1]),
      .a2    (a_w[2]),
      .c0    (cof[0]),
      .c3    (cof[3]),
      .c6    (cof[6]),
      .det   (det)
   );

   assign rsp.valid         = v_ff[N_ST-1];
   assign rsp.data.inv00    = inv[0];
   assign rsp.data.inv01    = inv[1];
   assign rsp.data.inv02    = inv[2];
   assign rsp.data.inv10    = inv[3];
   assign rsp.data.inv11    = inv[4];
   assign rsp.data.inv12    = inv[5];
   assign rsp.data.inv20    = inv[6];
   assign rsp.data.inv21    = inv[7];
   assign rsp.data.inv22    = inv[8];
   assign rsp.data.singular = sing_out_ff;

endmodule

[design/m3i_cof_lane.sv]
// ----------------------------------------------------------------------------
// m3i_cof_lane: one adjugate entry
// Two registered 32x32 products, then their exact difference.
// ----------------------------------------------------------------------------
module m3i_cof_lane (
   input  logic               clock,
   input  logic [1:0]         en,
   input  m3i_pkg::word_type  p,
   input  m3i_pkg::word_type  q,
   input  m3i_pkg::word_type  s,
   input  m3i_pkg::word_type  t,
   output m3i_pkg::cof_type   cof
);
   import m3i_pkg::*;

   logic signed [PROD_W-1:0] pq_ff, pq_in, st_ff, st_in;
   cof_type                  cof_ff, cof_in;

   assign pq_in  = p * q;
   assign st_in  = s * t;
   assign cof_in = COF_W'(pq_ff) - COF_W'(st_ff);
   assign cof    = cof_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         pq_ff <= pq_in;
         st_ff <= st_in;
      end
      if (en[1]) begin
         cof_ff <= cof_in;
      end
   end

endmodule

[design/m3i_det.sv]
// ----------------------------------------------------------------------------
// m3i_det: determinant merge
// Expands along row 0 using three lane cofactors. Each 32 x 65 product is
// split into two narrower partial products, then summed over two stages.
// ----------------------------------------------------------------------------
module m3i_det (
   input  logic                  clock,
   input  logic [m3i_pkg::ST_DET:0] en,
   input  m3i_pkg::word_type     a0,
   input  m3i_pkg::word_type     a1,
   input  m3i_pkg::word_type     a2,
   input  m3i_pkg::cof_type      c0,
   input  m3i_pkg::cof_type      c3,
   input  m3i_pkg::cof_type      c6,
   output m3i_pkg::det_type      det
);
   import m3i_pkg::*;

   word_type                 a_in [3];
   cof_type                  c_in [3];
   word_type                 a0_ff [3];
   word_type                 a1_ff [3];
   logic signed [PART_W-1:0] lo_ff [3];
   logic signed [PART_W-1:0] lo_in [3];
   logic signed [PART_W-1:0] hi_ff [3];
   logic signed [PART_W-1:0] hi_in [3];
   logic signed [DET_W-1:0]  term_ff [3];
   logic signed [DET_W-1:0]  term_in [3];
   logic signed [DET_W-1:0]  sum_ff, sum_in;
   det_type                  det_ff, det_in;

   assign a_in[0] = a0;
   assign a_in[1] = a1;
   assign a_in[2] = a2;
   assign c_in[0] = c0;
   assign c_in[1] = c3;
   assign c_in[2] = c6;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lo_in[i] = a1_ff[i] * $signed({1'b0, c_in[i][WORD_BITS-1:0]});
         hi_in[i] = a1_ff[i] * $signed(c_in[i][COF_W-1:WORD_BITS]);
         term_in[i] = (DET_W'(hi_ff[i]) <<< WORD_BITS) + DET_W'(lo_ff[i]);
      end
      sum_in = term_ff[0] + term_ff[1] + term_ff[2];
      det_in.neg      = sum_ff[DET_W-1];
      det_in.singular = (sum_ff == '0);
      det_in.mag      = sum_ff[DET_W-1] ? mag_type'(-sum_ff) : mag_type'(sum_ff);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (en[0]) a0_ff[i] <= a_in[i];
         if (en[1]) a1_ff[i] <= a0_ff[i];
         if (en[2]) begin
            lo_ff[i] <= lo_in[i];
            hi_ff[i] <= hi_in[i];
         end
         if (en[3]) term_ff[i] <= term_in[i];
      end
      if (en[4]) sum_ff <= sum_in;
      if (en[ST_DET]) det_ff <= det_in;
   end

   assign det = det_ff;

endmodule

[design/m3i_div_lane.sv]
// ----------------------------------------------------------------------------
// m3i_div_lane: one inverse element
// Pipelined restoring division of |cofactor| * 2^(2*FRAC_BITS) by |det|,
// one quotient bit per stage, then round half away from zero and saturate.
// ----------------------------------------------------------------------------
module m3i_div_lane (
   input  logic                  clock,
   input  m3i_pkg::stage_en_type en,
   input  m3i_pkg::cof_type      cof,
   input  m3i_pkg::det_type      det,
   input  m3i_pkg::dpipe_type    dpipe,
   input  logic                  sing,
   output m3i_pkg::word_type     inv
);
   import m3i_pkg::*;

   cof_type               c2_ff, c3_ff, c4_ff;
   cof_mag_type           cm_ff, cm_in;
   logic                  cn_ff;
   logic [NUM_W-1:0]      num;
   mag_type               rem_ff [WORD_BITS+1];
   mag_type               rem_in [WORD_BITS+1];
   logic [WORD_BITS-1:0]  q_ff [WORD_BITS+1];
   logic [WORD_BITS-1:0]  q_in [WORD_BITS+1];
   logic                  ovf_ff [WORD_BITS+1];
   logic                  neg_ff [WORD_BITS+1];
   logic                  ovf_in, neg_in;
   logic                  rbit;
   logic [QR_W-1:0]       qr, nqr;
   word_type              inv_ff, inv_in;

   assign cm_in = c4_ff[COF_W-1] ? cof_mag_type'(-c4_ff) : cof_mag_type'(c4_ff);

   // First stage: the quotient reaches 2^WORD_BITS exactly when the
   // numerator shifted down by WORD_BITS is not below the divisor.
   assign num       = {cm_ff, {(2*FRAC_BITS){1'b0}}};
   assign rem_in[0] = DET_W'(num >> WORD_BITS);
   assign q_in[0]   = '0;
   assign ovf_in    = (rem_in[0] >= det.mag);
   assign neg_in    = cn_ff ^ det.neg;

   // The remaining numerator bits are all zero since WORD_BITS <= 2*FRAC_BITS.
   for (genvar k = 1; k <= WORD_BITS; k++) begin : g_step
      logic [DET_W:0] two;
      assign two = {rem_ff[k-1], 1'b0};
      always_comb begin
         if (two >= {1'b0, dpipe[k-1]}) begin
            rem_in[k] = DET_W'(two - {1'b0, dpipe[k-1]});
            q_in[k]   = q_ff[k-1] | (WORD_BITS'(1) << (WORD_BITS - k));
         end else begin
            rem_in[k] = DET_W'(two);
            q_in[k]   = q_ff[k-1];
         end
      end
   end

   always_comb begin
      rbit = ({rem_ff[WORD_BITS], 1'b0} >= {1'b0, dpipe[WORD_BITS]});
      qr   = QR_W'(q_ff[WORD_BITS]) + QR_W'(rbit);
      nqr  = QR_W'(0) - qr;
      if (sing) begin
         inv_in = '0;
      end else if (!neg_ff[WORD_BITS]) begin
         inv_in = (ovf_ff[WORD_BITS] || qr > QR_POS_LIM) ? WORD_MAX
                                                         : word_type'(qr[WORD_BITS-1:0]);
      end else begin
         inv_in = (ovf_ff[WORD_BITS] || qr > QR_NEG_LIM) ? WORD_MIN
                                                         : word_type'(nqr[WORD_BITS-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) c2_ff <= cof;
      if (en[3]) c3_ff <= c2_ff;
      if (en[4]) c4_ff <= c3_ff;
      if (en[ST_DET]) begin
         cm_ff <= cm_in;
         cn_ff <= c4_ff[COF_W-1];
      end
      if (en[ST_D0]) begin
         rem_ff[0] <= rem_in[0];
         q_ff[0]   <= q_in[0];
         ovf_ff[0] <= ovf_in;
         neg_ff[0] <= neg_in;
      end
      for (int k = 1; k <= WORD_BITS; k++) begin
         if (en[ST_D0+k]) begin
            rem_ff[k] <= rem_in[k];
            q_ff[k]   <= q_in[k];
            ovf_ff[k] <= ovf_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
         end
      end
      if (en[N_ST-1]) inv_ff <= inv_in;
   end

   assign inv = inv_ff;

endmodule

[design/m3i_checker.sv]
// ----------------------------------------------------------------------------
// m3i_checker: port-level assertions for the matrix inverse
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module m3i_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input m3i_pkg::rsp_type rsp_data
);
   import m3i_pkg::*;

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("response changed while stalled");

   // A singular matrix gives an all-zero inverse.
   a_singular_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.singular |->
         rsp_data.inv00 == '0 && rsp_data.inv01 == '0 && rsp_data.inv02 == '0 &&
         rsp_data.inv10 == '0 && rsp_data.inv11 == '0 && rsp_data.inv12 == '0 &&
         rsp_data.inv20 == '0 && rsp_data.inv21 == '0 && rsp_data.inv22 == '0)
      else $error("singular response with nonzero element");

   // The pipeline only refuses a request when it is full and stalled.
   a_ready_only_full : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request refused with room in the pipeline");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind matrix3_inverse m3i_checker u_m3i_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_data  (rsp.data)
);
